### src/polyblep_oscillator_core_macros.svh
// Assertion macros for the oscillator core checker
`ifndef POLYBLEP_OSCILLATOR_CORE_MACROS_SVH
`define POLYBLEP_OSCILLATOR_CORE_MACROS_SVH

// same-cycle implication
`define PBO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbo check failed");

// next-cycle implication
`define PBO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbo check failed");

`endif

### src/pbo_pkg.sv
package pbo_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int SINE_DEPTH      = 1024;
  localparam int SINE_IDX_BITS   = $clog2(SINE_DEPTH);
  localparam int WAVE_W          = 2;
  localparam int INC_W           = 24;
  localparam int SAMPLE_W        = 18;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 24;
  localparam int DIV_STEPS       = 15;
  localparam int CNT_W           = $clog2(DIV_STEPS);
  localparam int MUL_W           = 33;
  localparam int SQ_W            = 20;
  localparam int ACC_W           = 32;
  localparam int Z_W             = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = CFG_IDX_W'(1);

  localparam logic signed [ACC_W-1:0] SIN_C_INIT = 32'sd172272;
  localparam logic signed [ACC_W-1:0] SIN_COEF [4] = '{
    -32'sd5026992, 32'sd85569304, -32'sd693598343, 32'sd1686629713
  };

  typedef enum logic [1:0] {
    WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_TRI
  } wave_t;

  typedef enum logic {
    KIND_TICK, KIND_RESTART
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_RESTART, OP_START, OP_SIN_ZZ, OP_SIN_Z2, OP_SIN_MUL, OP_SIN_ADD,
    OP_SIN_MULZ, OP_SIN_FIN, OP_BL_SETUP, OP_DIV_STEP, OP_BL_MUL, OP_BL_RES,
    OP_TRI_MUL, OP_TRI_ACC, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIN_ZZ, ST_SIN_Z2, ST_SIN_MUL, ST_SIN_ADD, ST_SIN_MULZ,
    ST_SIN_FIN, ST_BL_SETUP, ST_BL_DIV, ST_BL_MUL, ST_BL_RES, ST_TRI_MUL,
    ST_TRI_ACC, ST_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       pass;
    logic [1:0] coef_sel;
  } cmd_t;

  typedef struct packed {
    wave_t wave;
    logic  hit0;
    logic  hit1;
    logic  out_free;
  } status_t;

endpackage

### src/pbo_ctrl.sv
module pbo_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_kind,
  input  pbo_pkg::status_t sts,
  output pbo_pkg::cmd_t   cmd
);
  import pbo_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             pass_r, pass_nxt;
  logic             hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign hit = pass_r ? sts.hit1 : sts.hit0;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    pass_nxt     = pass_r;
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.pass     = pass_r;
    cmd.coef_sel = k_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_RESTART) begin
            cmd.op = OP_RESTART;
          end else begin
            cmd.op   = OP_START;
            pass_nxt = 1'b0;
            k_nxt    = '0;
            state_nxt = (sts.wave == WAVE_SINE) ? ST_SIN_ZZ : ST_BL_SETUP;
          end
        end
      end
      ST_SIN_ZZ: begin
        cmd.op    = OP_SIN_ZZ;
        state_nxt = ST_SIN_Z2;
      end
      ST_SIN_Z2: begin
        cmd.op    = OP_SIN_Z2;
        state_nxt = ST_SIN_MUL;
      end
      ST_SIN_MUL: begin
        cmd.op    = OP_SIN_MUL;
        state_nxt = ST_SIN_ADD;
      end
      ST_SIN_ADD: begin
        cmd.op = OP_SIN_ADD;
        k_nxt  = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? ST_SIN_MULZ : ST_SIN_MUL;
      end
      ST_SIN_MULZ: begin
        cmd.op    = OP_SIN_MULZ;
        state_nxt = ST_SIN_FIN;
      end
      ST_SIN_FIN: begin
        cmd.op    = OP_SIN_FIN;
        state_nxt = ST_OUT;
      end
      ST_BL_SETUP: begin
        cmd.op = OP_BL_SETUP;
        cnt_nxt = '0;
        if (hit) begin
          state_nxt = ST_BL_DIV;
        end else if (!pass_r && (sts.wave == WAVE_SQUARE || sts.wave == WAVE_TRI)) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_BL_SETUP;
        end else if (sts.wave == WAVE_TRI) begin
          state_nxt = ST_TRI_MUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_BL_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_BL_MUL;
      end
      ST_BL_MUL: begin
        cmd.op    = OP_BL_MUL;
        state_nxt = ST_BL_RES;
      end
      ST_BL_RES: begin
        cmd.op = OP_BL_RES;
        if (!pass_r && (sts.wave == WAVE_SQUARE || sts.wave == WAVE_TRI)) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_BL_SETUP;
        end else if (sts.wave == WAVE_TRI) begin
          state_nxt = ST_TRI_MUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_TRI_MUL: begin
        cmd.op    = OP_TRI_MUL;
        state_nxt = ST_TRI_ACC;
      end
      ST_TRI_ACC: begin
        cmd.op    = OP_TRI_ACC;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### src/pbo_datapath.sv
module pbo_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [pbo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbo_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [pbo_pkg::INC_W-1:0]          in_start_phase,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pbo_pkg::SAMPLE_W-1:0] out_sample,
  input  pbo_pkg::cmd_t                      cmd,
  output pbo_pkg::status_t                   sts
);
  import pbo_pkg::*;

  localparam int PB    = PHASE_BITS;
  localparam int ZPAD  = 30 - (SINE_IDX_BITS - 2);
  localparam int TRI_W = 29;

  wave_t                     wave_r;
  logic [PB-1:0]             inc_r;
  logic [PB-1:0]             phase_r;
  logic signed [PB-1:0]      integ_r;
  logic signed [SQ_W-1:0]    sq_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [Z_W-1:0]            z2_r;
  logic signed [2*MUL_W-1:0] prod_r;
  logic [PB-1:0]             rem_r;
  logic [DIV_STEPS-1:0]      quot_r;
  logic                      case1_r;
  logic signed [16:0]        s_r;
  logic                      out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic [SINE_IDX_BITS-1:0]  idx;
  logic [1:0]                quad;
  logic [29:0]               zb;
  logic [Z_W-1:0]            z;
  logic [PB-1:0]             tp0, tp1, tp;
  logic [PB:0]               sum0, sum1;
  logic                      c1_0, c1_1, hit0, hit1, c1_sel;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [27:0]        d;
  logic [PB:0]               rem_sh;
  logic                      ge;
  logic [14:0]               uush;
  logic signed [SQ_W-1:0]    u2, blep_r;
  logic signed [35:0]        sv;
  logic [19:0]               sm;
  logic [14:0]               smag;
  logic signed [TRI_W-1:0]   tri_sum;
  logic signed [SQ_W-1:0]    y;

  assign idx  = phase_r[PB-1 -: SINE_IDX_BITS];
  assign quad = idx[SINE_IDX_BITS-1 -: 2];
  assign zb   = {idx[SINE_IDX_BITS-3:0], {ZPAD{1'b0}}};
  assign z    = quad[0] ? (Z_W'(1) << 30) - Z_W'(zb) : Z_W'(zb);

  assign tp0  = phase_r;
  assign tp1  = phase_r + (PB'(1) << (PB - 1));
  assign sum0 = {1'b0, tp0} + {1'b0, inc_r};
  assign sum1 = {1'b0, tp1} + {1'b0, inc_r};
  assign c1_0 = tp0 < inc_r;
  assign c1_1 = tp1 < inc_r;
  assign hit0 = c1_0 || (sum0[PB] && sum0[PB-1:0] != '0);
  assign hit1 = c1_1 || (sum1[PB] && sum1[PB-1:0] != '0);
  assign tp     = cmd.pass ? tp1 : tp0;
  assign c1_sel = cmd.pass ? c1_1 : c1_0;

  assign sts.wave     = wave_r;
  assign sts.hit0     = hit0;
  assign sts.hit1     = hit1;
  assign sts.out_free = !out_valid_r || out_ready;

  assign d = (28'(sq_r) <<< 7) - 28'(integ_r);

  always_comb begin
    case (cmd.op)
      OP_SIN_ZZ: begin
        mul_a = MUL_W'(z);
        mul_b = MUL_W'(z);
      end
      OP_SIN_MUL: begin
        mul_a = MUL_W'(acc_r);
        mul_b = MUL_W'(z2_r);
      end
      OP_SIN_MULZ: begin
        mul_a = MUL_W'(acc_r);
        mul_b = MUL_W'(z);
      end
      OP_BL_MUL: begin
        mul_a = MUL_W'(quot_r);
        mul_b = MUL_W'(quot_r);
      end
      OP_TRI_MUL: begin
        mul_a = MUL_W'(d);
        mul_b = MUL_W'(inc_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, inc_r};

  assign uush   = prod_r[29:15];
  assign u2     = $signed(SQ_W'({quot_r, 1'b0}));
  assign blep_r = case1_r ? u2 - $signed(SQ_W'(uush)) - SQ_W'(32768)
                          : $signed(SQ_W'(uush)) - u2 + SQ_W'(32768);

  assign sv   = 36'(prod_r >>> 30);
  assign sm   = 20'((sv[34:0] + 35'd16384) >> 15);
  assign smag = sv[35] ? 15'd0 : (sm > 20'd32767) ? 15'd32767 : sm[14:0];

  assign tri_sum = TRI_W'(integ_r) + TRI_W'(prod_r >>> PB);

  always_comb begin
    case (wave_r)
      WAVE_SINE: y = SQ_W'(s_r);
      WAVE_TRI:  y = SQ_W'(integ_r >>> 5);
      default:   y = sq_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_START: begin
        if (wave_r == WAVE_SAW)
          sq_r <= $signed(SQ_W'(phase_r[PB-1 -: 16])) - SQ_W'(32768);
        else
          sq_r <= phase_r[PB-1] ? -SQ_W'(32768) : SQ_W'(32768);
      end
      OP_SIN_Z2: begin
        z2_r  <= prod_r[60:30];
        acc_r <= SIN_C_INIT;
      end
      OP_SIN_ADD:  acc_r <= SIN_COEF[cmd.coef_sel] + ACC_W'(prod_r >>> 30);
      OP_SIN_FIN:  s_r <= quad[1] ? -$signed(17'(smag)) : $signed(17'(smag));
      OP_BL_SETUP: begin
        rem_r   <= c1_sel ? tp : PB'(0) - tp;
        quot_r  <= '0;
        case1_r <= c1_sel;
      end
      OP_DIV_STEP: begin
        rem_r  <= ge ? PB'(rem_sh - {1'b0, inc_r}) : rem_sh[PB-1:0];
        quot_r <= {quot_r[DIV_STEPS-2:0], ge};
      end
      OP_BL_RES: begin
        if (cmd.pass || wave_r == WAVE_SAW) sq_r <= sq_r - blep_r;
        else sq_r <= sq_r + blep_r;
      end
      OP_OUT: begin
        if (y > SQ_W'(131071)) out_sample_r <= 18'sd131071;
        else if (y < -SQ_W'(131072)) out_sample_r <= -18'sd131072;
        else out_sample_r <= SAMPLE_W'(y);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r      <= WAVE_SINE;
      inc_r       <= '0;
      phase_r     <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WAVEFORM:  wave_r <= wave_t'(cfg_data[WAVE_W-1:0]);
          CFG_PHASE_INC: inc_r  <= cfg_data[PB-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_RESTART: begin
          phase_r <= in_start_phase[PB-1:0];
          integ_r <= '0;
        end
        OP_TRI_ACC: begin
          if (tri_sum > TRI_W'(8388607)) integ_r <= 24'sd8388607;
          else if (tri_sum < -TRI_W'(8388608)) integ_r <= -24'sd8388608;
          else integ_r <= PB'(tri_sum);
        end
        OP_OUT: phase_r <= phase_r + inc_r;
        default: ;
      endcase
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

### src/polyblep_oscillator_core.sv
// Band-limited audio oscillator.
// Channels: in_* carries one item (kind, start_phase); kind tick makes one
// sample, kind restart loads the phase, clears the triangle integrator and
// makes no sample. out_* carries one saturated Q2.15 sample per tick.
// cfg_* writes waveform (index 0) or phase_inc (index 1); cfg_ready is
// always high. Write configuration only while the block is idle.
// A sine tick runs on the single shared multiplier: square z, take z^2,
// four multiply-add steps, multiply by z, then round and set the sign.
// Saw, square and triangle run a BLEP pass for each edge hit (setup, the
// one-bit-per-cycle divider for 15 quotient bits, square and write-back);
// triangle then multiplies and accumulates into the integrator.
// A restart is taken while idle and leaves the controller idle.
// in_ready is high only while the controller is idle; the next item may
// be taken while a finished sample waits in the output register.
// If the receiver stalls, the finished sample is held and the controller
// waits before overwriting it.
// Reset (rst_n low, synchronous) clears phase, integrator, waveform,
// phase_inc and controller state, and drops out_valid.
module polyblep_oscillator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [pbo_pkg::INC_W-1:0]           in_start_phase,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pbo_pkg::SAMPLE_W-1:0] out_sample
);
  import pbo_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  pbo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbo_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_start_phase (in_start_phase),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

### src/pbo_checker.sv
`include "polyblep_oscillator_core_macros.svh"

module pbo_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_ready,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_kind,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pbo_pkg::SAMPLE_W-1:0] out_sample
);
  import pbo_pkg::*;

  `PBO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample))
  `PBO_ASSERT_NXT(a_restart_silent, in_valid && in_ready && in_kind == KIND_RESTART,
                  !$rose(out_valid))
  `PBO_ASSERT_NXT(a_tick_busy, in_valid && in_ready && in_kind == KIND_TICK, !in_ready)
  `PBO_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind polyblep_oscillator_core pbo_checker u_pbo_checker (.*);

### sim/polyblep_oscillator_core_checker.sv
`timescale 1ns / 100ps
module polyblep_oscillator_core_checker
  import pbo_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_kind,
  input  logic [INC_W-1:0]           in_start_phase,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  output int                         fail_count,
  output int                         pending_samples
);

  localparam longint PH_ONE  = 64'd1 << PHASE_BITS;
  localparam longint PH_HALF = 64'd1 << (PHASE_BITS - 1);
  localparam longint PH_MASK = PH_ONE - 1;

  wave_t                       cur_wave;
  longint                      cur_inc;
  longint                      phase;
  longint                      integ;
  logic signed [SAMPLE_W-1:0]  sample_q[$];

  function automatic longint blep_resid(longint t, longint dt);
    longint u;
    if (t < dt) begin
      u = (t << 15) / dt;
      return 2 * u - ((u * u) >> 15) - 32768;
    end
    if (t + dt > PH_ONE) begin
      u = ((PH_ONE - t) << 15) / dt;
      return ((u * u) >> 15) - 2 * u + 32768;
    end
    return 0;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint sine_val(longint t);
    longint idx, a, z, z2, acc, s;
    int     quad;
    idx  = (t * SINE_DEPTH) >> PHASE_BITS;
    a    = (idx << 32) / SINE_DEPTH;
    quad = int'((a >> 30) & 3);
    z    = a & 64'h3FFF_FFFF;
    if (quad & 1) z = (64'd1 << 30) - z;
    z2  = (z * z) >> 30;
    acc = 172272;
    acc = -5026992 + mul_q30(acc, z2);
    acc = 85569304 + mul_q30(acc, z2);
    acc = -693598343 + mul_q30(acc, z2);
    acc = 1686629713 + mul_q30(acc, z2);
    s   = mul_q30(acc, z);
    if (s < 0) s = 0;
    s = (s + 16384) >> 15;
    if (s > 32767) s = 32767;
    return (quad & 2) ? -s : s;
  endfunction

  function automatic longint square_val(longint t, longint dt);
    longint sq;
    sq = (t < PH_HALF) ? 32768 : -32768;
    sq += blep_resid(t, dt);
    sq -= blep_resid((t + PH_HALF) & PH_MASK, dt);
    return sq;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] osc_tick();
    longint t, dt, y, d;
    t  = phase;
    dt = cur_inc;
    case (cur_wave)
      WAVE_SINE:   y = sine_val(t);
      WAVE_SAW:    y = (t >> (PHASE_BITS - 16)) - 32768 - blep_resid(t, dt);
      WAVE_SQUARE: y = square_val(t, dt);
      default: begin
        d = square_val(t, dt) * 128 - integ;
        integ += (d * dt) >>> PHASE_BITS;
        if (integ > 8388607) integ = 8388607;
        if (integ < -8388608) integ = -8388608;
        y = integ >>> 5;
      end
    endcase
    if (y > 131071) y = 131071;
    if (y < -131072) y = -131072;
    phase = (t + dt) & PH_MASK;
    return y[SAMPLE_W-1:0];
  endfunction

  assign pending_samples = sample_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_wave   = WAVE_SINE;
      cur_inc    = 0;
      phase      = 0;
      integ      = 0;
      fail_count = 0;
      sample_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WAVEFORM) cur_wave = wave_t'(cfg_data[WAVE_W-1:0]);
        else if (cfg_index == CFG_PHASE_INC) cur_inc = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          $error("unexpected sample %0d", out_sample);
          fail_count++;
        end else begin
          logic signed [SAMPLE_W-1:0] exp_s;
          exp_s = sample_q.pop_front();
          if (exp_s !== out_sample) begin
            $error("sample mismatch: expected %0d, actual %0d", exp_s, out_sample);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (kind_t'(in_kind) == KIND_RESTART) begin
          phase = in_start_phase;
          integ = 0;
        end else begin
          sample_q.push_back(osc_tick());
        end
      end
    end
  end

endmodule

### sim/tb_polyblep_oscillator_core.sv
`timescale 1ns / 100ps
module tb_polyblep_oscillator_core;
  import pbo_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_kind;
  logic [INC_W-1:0]           in_start_phase;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  int fail_count;
  int pending_samples;
  int tx_idle_pct;
  int rx_idle_pct;
  bit long_hold;
  int hold_cnt;
  int quiet_cycles;
  int n_ticks;
  int n_restarts;

  polyblep_oscillator_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_start_phase (in_start_phase),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample)
  );

  polyblep_oscillator_core_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_start_phase  (in_start_phase),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .fail_count      (fail_count),
    .pending_samples (pending_samples)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  = 0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= 300) begin
        long_hold = 1'b0;
        hold_cnt  = 0;
      end
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(kind_t kind, logic [INC_W-1:0] start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_start_phase <= start;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_RESTART) n_restarts++;
    else n_ticks++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_samples != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_osc(wave_t wave, logic [INC_W-1:0] inc);
    cfg_write(CFG_WAVEFORM, CFG_DATA_W'(wave));
    cfg_write(CFG_PHASE_INC, inc);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [INC_W-1:0] pick_phase();
    case ($urandom_range(3))
      0:       return INC_W'($urandom_range(255));
      1:       return ~INC_W'($urandom_range(255));
      2:       return 24'h80_0000 ^ INC_W'($urandom_range(511));
      default: return INC_W'($urandom);
    endcase
  endfunction

  function automatic logic [INC_W-1:0] pick_inc(int sel);
    case (sel)
      0:       return '0;
      1:       return 24'd1;
      2:       return 24'h80_0000;
      3:       return 24'hFF_FFFF;
      4:       return INC_W'($urandom_range(24'h08_0000, 1));
      default: return INC_W'($urandom_range(24'h80_0000));
    endcase
  endfunction

  initial begin
    wave_t wave;
    logic [INC_W-1:0] inc;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_kind        = 1'b0;
    in_start_phase = '0;
    long_hold      = 1'b0;
    tx_idle_pct    = 12;
    rx_idle_pct    = 55;
    n_ticks        = 0;
    n_restarts     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then edges of phase and increment per waveform
    repeat (3) send_item(KIND_TICK, '0);
    for (int w = 0; w < 4; w++) begin
      wait_idle();
      set_osc(wave_t'(w), (w == 1) ? 24'hFF_FFFF : 24'h0C_0000);
      send_item(KIND_RESTART, 24'hFF_FFFF);
      send_item(KIND_TICK, 24'hFF_FFFF);
      send_item(KIND_RESTART, 24'h7F_FFFF);
      send_item(KIND_TICK, '0);
      send_item(KIND_RESTART, '0);
      send_item(KIND_TICK, '0);
    end

    for (int p = 0; p < 24; p++) begin
      wait_idle();
      if (p == 8) begin
        tx_idle_pct = 55;
        rx_idle_pct = 12;
      end else if (p == 16) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wave = wave_t'(p % 4);
      inc  = pick_inc((p / 4 + p) % 6);
      set_osc(wave, inc);
      if (p == 18) long_hold = 1'b1;
      for (int i = 0; i < 43; i++) begin
        if ($urandom_range(9) == 0) send_item(KIND_RESTART, pick_phase());
        else send_item(KIND_TICK, INC_W'($urandom));
      end
    end

    wait_idle();
    $display("Covered %0d ticks and %0d restarts over four waveforms,", n_ticks, n_restarts);
    $display("increments from zero to full scale, with stalls on both sides.");
    if (fail_count == 0 && pending_samples == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/pbo_pkg.sv
src/pbo_ctrl.sv
src/pbo_datapath.sv
src/polyblep_oscillator_core.sv
src/pbo_checker.sv
sim/polyblep_oscillator_core_checker.sv
sim/tb_polyblep_oscillator_core.sv
